>>> rtl/core/i2p_pkg.sv
// Shared types, character codes and helpers for the infix-to-postfix converter.
// Depends on nothing. All other files import it.
`timescale 1ns / 1ps
`default_nettype none

package i2p_pkg;

  // Operator stack depth and bracket counter width.
  localparam int STACK_DEPTH = 16;
  localparam int COUNT_BITS  = 16;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = $clog2(STACK_DEPTH);

  // Command queue between front and back.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Stack codes.
  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_SUB    = 3'd1;
  localparam logic [2:0] OP_MUL    = 3'd2;
  localparam logic [2:0] OP_DIV    = 3'd3;
  localparam logic [2:0] OP_LPAREN = 3'd4;

  // Characters.
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_NUL    = 8'h00;

  typedef enum logic [2:0] {
    K_OPER,
    K_LPAREN,
    K_RPAREN,
    K_OPERAND,
    K_END
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] ch;    // operand character
    logic [2:0] code;  // operator code
    logic       ok;    // verdict, end command only
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] stack_count;
    logic             busy;
  } back_status_t;

  function automatic logic [1:0] prec(input logic [2:0] code);
    case (code)
      OP_ADD, OP_SUB: prec = 2'd1;
      OP_MUL, OP_DIV: prec = 2'd2;
      default:        prec = 2'd0;
    endcase
  endfunction

  function automatic logic [7:0] code_char(input logic [2:0] code);
    case (code)
      OP_ADD:    code_char = CH_PLUS;
      OP_SUB:    code_char = CH_MINUS;
      OP_MUL:    code_char = CH_STAR;
      OP_DIV:    code_char = CH_SLASH;
      OP_LPAREN: code_char = CH_LPAREN;
      default:   code_char = CH_NUL;
    endcase
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/infix_to_postfix_converter_top.sv
// Top level of the infix-to-postfix converter: front end, command queue and
// back end with the operator stack. Depends on i2p_pkg and the three i2p modules.
//
// Usage:
//   Input stream (s_*): one item per infix character. s_tuser = 0 carries an
//   expression character in s_tdata[7:0]; s_tuser = 1 ends the expression.
//   Output stream (m_*): one item per postfix character (m_tuser = 1), then one
//   done item (m_tlast = 1, m_tuser = 0) that carries the verdict and the
//   overflow flag. On a done item with expr_ok = 0 the receiver discards the run.
//   Path: with the back idle, an accepted character is written to the queue,
//   fetched into the command register, then loaded into the output register.
//   Throughput: the front takes one item per cycle while the 4-entry command
//   queue has room. The back fetches a command, emits its characters and
//   does any push before it fetches the next one; the back sets the rate.
//   When the receiver stalls, the output register holds its item, the back
//   waits, the queue fills and s_tready falls; nothing is lost.
//   Reset (rst, synchronous) empties the queue and the stack and clears all
//   validation state. The state also returns to reset after each done item.
`timescale 1ns / 1ps
`default_nettype none

module infix_to_postfix_converter_top import i2p_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] in_char
  input  wire logic        s_tuser,   // [0] req_type (1 = end of expression)
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [7:0] out_char, [8] expr_ok,
                                      // [9] stack_overflow, [15:10] zero
  output logic             m_tuser,   // [0] char_valid
  output logic             m_tlast    // done_res
);

  logic         q_full;
  logic         q_empty;
  logic         q_push;
  logic         q_pop;
  cmd_t         q_cmd;
  cmd_t         q_head;
  logic [7:0]   out_char;
  logic         out_done;
  logic         out_ok;
  logic         out_ovf;
  back_status_t back_status;

  // Front: classification and expression checks.
  i2p_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_end   (s_tuser),
    .in_char  (s_tdata),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  // Decoupling queue.
  i2p_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  // Back: stack sequencer and output register.
  i2p_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_head    (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_char  (out_char),
    .out_done  (out_done),
    .out_ok    (out_ok),
    .out_ovf   (out_ovf),
    .status    (back_status)
  );

  assign m_tdata = {6'b0, out_ovf, out_ok, out_char};
  assign m_tuser = !out_done;
  assign m_tlast = out_done;

  // The stack never holds more entries than it has.
  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    back_status.stack_count <= CNT_W'(STACK_DEPTH))
    else $error("operator stack count beyond depth");

  // Character items carry no verdict bits.
  a_char_flags: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> (m_tuser && !m_tdata[8] && !m_tdata[9]))
    else $error("verdict bits set on a character item");

  // The done item comes only once the stack is drained.
  a_done_drained: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid && m_tlast) |-> ($past(back_status.stack_count) == '0))
    else $error("done item issued with operators left on the stack");

  // Input is held off only while the queue is full.
  a_ready_queue: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> q_full)
    else $error("input stalled with room in the queue");

endmodule

`default_nettype wire

>>> rtl/core/i2p_front.sv
// Front end: accepts input items, tracks validation state, classifies each
// character into a command for the queue. Depends on i2p_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2p_front import i2p_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       in_end,
  input  wire logic [7:0] in_char,
  input  wire logic       q_full,
  output logic            q_push,
  output cmd_t            q_cmd
);

  logic [COUNT_BITS-1:0] open_count, open_count_next;
  logic [COUNT_BITS-1:0] close_count, close_count_next;
  logic                  prev_was_op, prev_was_op_next;
  logic [7:0]            first_char, first_char_next;
  logic                  first_seen, first_seen_next;
  logic                  invalid_seen, invalid_seen_next;
  logic                  accept;
  logic                  is_space;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign is_space = (in_char == CH_SPACE) || (in_char inside {[8'd9:8'd13]});

  always_comb begin
    open_count_next   = open_count;
    close_count_next  = close_count;
    prev_was_op_next  = prev_was_op;
    first_char_next   = first_char;
    first_seen_next   = first_seen;
    invalid_seen_next = invalid_seen;
    q_push            = 1'b0;
    q_cmd.kind        = K_OPERAND;
    q_cmd.ch          = in_char;
    q_cmd.code        = OP_ADD;
    q_cmd.ok          = 1'b0;

    if (accept) begin
      if (in_end) begin
        q_push            = 1'b1;
        q_cmd.kind        = K_END;
        q_cmd.ok          = !invalid_seen && (open_count == close_count) && !prev_was_op;
        open_count_next   = '0;
        close_count_next  = '0;
        prev_was_op_next  = 1'b0;
        first_char_next   = '0;
        first_seen_next   = 1'b0;
        invalid_seen_next = 1'b0;
      end else begin
        if (!first_seen) begin
          first_seen_next = 1'b1;
          first_char_next = in_char;
        end
        if (!is_space) begin
          q_push = 1'b1;
          case (in_char)
            CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH: begin
              // first_char_next already holds this char if it opens the expression
              if (first_char_next == in_char || prev_was_op) begin
                invalid_seen_next = 1'b1;
              end
              prev_was_op_next = 1'b1;
              q_cmd.kind       = K_OPER;
              case (in_char)
                CH_PLUS:  q_cmd.code = OP_ADD;
                CH_MINUS: q_cmd.code = OP_SUB;
                CH_STAR:  q_cmd.code = OP_MUL;
                default:  q_cmd.code = OP_DIV;
              endcase
            end
            CH_LPAREN: begin
              open_count_next  = open_count + 1'b1;
              prev_was_op_next = 1'b0;
              q_cmd.kind       = K_LPAREN;
            end
            CH_RPAREN: begin
              close_count_next = close_count + 1'b1;
              prev_was_op_next = 1'b0;
              q_cmd.kind       = K_RPAREN;
            end
            default: begin
              if (!(in_char inside {[8'h30:8'h39]})) begin
                invalid_seen_next = 1'b1;
              end
              prev_was_op_next = 1'b0;
              q_cmd.kind       = K_OPERAND;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open_count   <= '0;
      close_count  <= '0;
      prev_was_op  <= 1'b0;
      first_char   <= '0;
      first_seen   <= 1'b0;
      invalid_seen <= 1'b0;
    end else begin
      open_count   <= open_count_next;
      close_count  <= close_count_next;
      prev_was_op  <= prev_was_op_next;
      first_char   <= first_char_next;
      first_seen   <= first_seen_next;
      invalid_seen <= invalid_seen_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/i2p_queue.sv
// Small register FIFO of commands between front and back.
// Depends on i2p_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2p_queue import i2p_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  cmd_t      push_cmd,
  input  wire logic pop,
  output cmd_t      head,
  output logic      empty,
  output logic      full
);

  cmd_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;
  logic              do_push;
  logic              do_pop;

  assign empty   = (fill == '0);
  assign full    = (fill == QCNT_W'(QDEPTH));
  assign head    = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/i2p_back.sv
// Back end: executes queued commands against the operator stack and drives
// the output register, at most one item per cycle. Depends on i2p_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2p_back import i2p_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  cmd_t       q_head,
  input  wire logic  q_empty,
  output logic       q_pop,
  output logic       out_valid,
  input  wire logic  out_ready,
  output logic [7:0] out_char,
  output logic       out_done,
  output logic       out_ok,
  output logic       out_ovf,
  output back_status_t status
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_SPACE
  } state_t;

  state_t           state;
  cmd_t             cmd;
  logic             space_to_eval;
  logic [2:0]       op_stack [STACK_DEPTH];
  logic [CNT_W-1:0] stack_count;
  logic             overflow_seen;
  logic [CNT_W-1:0] count_dec;
  logic [IDX_W-1:0] top_idx;
  logic [2:0]       top_code;
  logic             nonempty;
  logic             stack_full;
  logic             slot_free;
  logic             oper_pops;
  logic             out_load;

  assign count_dec  = stack_count - 1'b1;
  assign top_idx    = count_dec[IDX_W-1:0];
  assign top_code   = op_stack[top_idx];
  assign nonempty   = (stack_count != '0);
  assign stack_full = (stack_count >= CNT_W'(STACK_DEPTH));
  assign slot_free  = !out_valid || out_ready;
  assign oper_pops  = nonempty && (top_code <= OP_DIV) && (prec(top_code) >= prec(cmd.code));
  assign q_pop      = (state == S_IDLE) && !q_empty;

  // output register takes a new item this cycle
  assign out_load = slot_free &&
                    ((state == S_SPACE) ||
                     ((state == S_EVAL) &&
                      ((cmd.kind == K_OPERAND) || (cmd.kind == K_END) ||
                       ((cmd.kind == K_OPER) && oper_pops) ||
                       ((cmd.kind == K_RPAREN) && nonempty))));

  assign status.stack_count = stack_count;
  assign status.busy        = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      stack_count   <= '0;
      overflow_seen <= 1'b0;
      out_valid     <= 1'b0;
      space_to_eval <= 1'b0;
    end else begin
      out_valid <= out_load || (out_valid && !out_ready);
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            cmd   <= q_head;
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (slot_free) begin
            case (cmd.kind)
              K_OPERAND: begin
                out_char      <= cmd.ch;
                out_done      <= 1'b0;
                out_ok        <= 1'b0;
                out_ovf       <= 1'b0;
                space_to_eval <= 1'b0;
                state         <= S_SPACE;
              end
              K_OPER, K_LPAREN: begin
                if (cmd.kind == K_OPER && oper_pops) begin
                  out_char      <= code_char(top_code);
                  out_done      <= 1'b0;
                  out_ok        <= 1'b0;
                  out_ovf       <= 1'b0;
                  stack_count   <= count_dec;
                  space_to_eval <= 1'b1;
                  state         <= S_SPACE;
                end else begin
                  // push; a full stack drops the symbol
                  if (stack_full) begin
                    overflow_seen <= 1'b1;
                  end else begin
                    op_stack[stack_count[IDX_W-1:0]] <=
                      (cmd.kind == K_LPAREN) ? OP_LPAREN : cmd.code;
                    stack_count <= stack_count + 1'b1;
                  end
                  state <= S_IDLE;
                end
              end
              K_RPAREN: begin
                if (nonempty && top_code != OP_LPAREN) begin
                  out_char      <= code_char(top_code);
                  out_done      <= 1'b0;
                  out_ok        <= 1'b0;
                  out_ovf       <= 1'b0;
                  stack_count   <= count_dec;
                  space_to_eval <= 1'b1;
                  state         <= S_SPACE;
                end else begin
                  if (nonempty) begin
                    // matched bracket: extra space, discard the '('
                    out_char    <= CH_SPACE;
                    out_done    <= 1'b0;
                    out_ok      <= 1'b0;
                    out_ovf     <= 1'b0;
                    stack_count <= count_dec;
                  end
                  state <= S_IDLE;
                end
              end
              K_END: begin
                if (nonempty) begin
                  out_char      <= code_char(top_code);
                  out_done      <= 1'b0;
                  out_ok        <= 1'b0;
                  out_ovf       <= 1'b0;
                  stack_count   <= count_dec;
                  space_to_eval <= 1'b1;
                  state         <= S_SPACE;
                end else begin
                  out_char      <= CH_NUL;
                  out_done      <= 1'b1;
                  out_ok        <= cmd.ok;
                  out_ovf       <= overflow_seen;
                  overflow_seen <= 1'b0;
                  state         <= S_IDLE;
                end
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_SPACE: begin
          if (slot_free) begin
            out_char  <= CH_SPACE;
            out_done  <= 1'b0;
            out_ok    <= 1'b0;
            out_ovf   <= 1'b0;
            state     <= space_to_eval ? S_EVAL : S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> tb/tb_infix_to_postfix_converter_top.sv
// Self-checking testbench for infix_to_postfix_converter_top: streams infix text
// through the slave side and checks each postfix item against a local shunting-yard model.
// Depends on i2p_pkg and the converter RTL.
`timescale 1ns / 1ps

module tb_infix_to_postfix_converter_top;
  import i2p_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 430;
  localparam int PHASE_LEN    = 50;   // accepted items per idling phase
  localparam int HOLD_AT      = 200;  // accepted items before the long receiver hold
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 40;

  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_VT   = 8'h0B;
  localparam logic [7:0] CH_FF   = 8'h0C;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_HIGH = 8'hFF;

  typedef struct packed {
    logic       is_end;
    logic [7:0] ch;
  } infix_item_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       ch_valid;
    logic       done;
    logic       ok;
    logic       ovf;
  } postfix_item_t;

  // DUT connections; the driven ones are known from time zero
  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = '0;   // [7:0] in_char
  logic        s_tuser  = 1'b0; // [0] req_type
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;         // [7:0] out_char, [8] expr_ok, [9] stack_overflow
  logic        m_tuser;         // [0] char_valid
  logic        m_tlast;         // done_res

  infix_item_t   infix_q[$];    // items waiting to be offered
  postfix_item_t postfix_q[$];  // postfix items still to come

  int n_accepted = 0;
  int n_errors   = 0;
  int n_cycles   = 0;
  int hold_left  = 0;
  bit hold_used  = 1'b0;

  // Converter state of the model
  logic [2:0]            op_stk [STACK_DEPTH];
  int                    stk_n;
  logic [COUNT_BITS-1:0] opens;
  logic [COUNT_BITS-1:0] closes;
  logic                  after_op;
  logic                  seen_first;
  logic                  bad_expr;
  logic                  overflowed;
  logic [7:0]            lead_ch;

  infix_to_postfix_converter_top uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shunting-yard model
  // ---------------------------------------------------------------------------
  function automatic bit is_blank(input logic [7:0] ch);
    return ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR);
  endfunction

  function automatic int rank(input logic [2:0] code);
    return (code == OP_MUL || code == OP_DIV) ? 2 : 1;
  endfunction

  function automatic logic [7:0] stack_sym(input logic [2:0] code);
    case (code)
      OP_ADD:  return CH_PLUS;
      OP_SUB:  return CH_MINUS;
      OP_MUL:  return CH_STAR;
      OP_DIV:  return CH_SLASH;
      default: return CH_LPAREN;
    endcase
  endfunction

  task automatic clear_expr();
    stk_n      = 0;
    opens      = '0;
    closes     = '0;
    after_op   = 1'b0;
    seen_first = 1'b0;
    bad_expr   = 1'b0;
    overflowed = 1'b0;
    lead_ch    = CH_NUL;
  endtask

  task automatic emit_char(input logic [7:0] ch);
    postfix_q.push_back('{ch, 1'b1, 1'b0, 1'b0, 1'b0});
  endtask

  task automatic pop_to_output();
    emit_char(stack_sym(op_stk[stk_n-1]));
    emit_char(CH_SPACE);
    stk_n--;
  endtask

  // a push onto a full stack is dropped and flagged
  task automatic push_code(input logic [2:0] code);
    if (stk_n >= STACK_DEPTH) begin
      overflowed = 1'b1;
    end else begin
      op_stk[stk_n] = code;
      stk_n++;
    end
  endtask

  task automatic convert_char(input logic is_end, input logic [7:0] ch);
    logic [2:0] code;
    logic       is_op;
    is_op = 1'b1;
    code  = OP_ADD;
    case (ch)
      CH_PLUS:  code = OP_ADD;
      CH_MINUS: code = OP_SUB;
      CH_STAR:  code = OP_MUL;
      CH_SLASH: code = OP_DIV;
      default:  is_op = 1'b0;
    endcase
    if (is_end) begin
      while (stk_n > 0) pop_to_output();
      postfix_q.push_back('{CH_NUL, 1'b0, 1'b1,
                            !bad_expr && opens == closes && !after_op, overflowed});
      clear_expr();
    end else begin
      // first raw character counts even when it is blank
      if (!seen_first) begin
        seen_first = 1'b1;
        lead_ch    = ch;
      end
      if (!is_blank(ch)) begin
        if (is_op) begin
          if (lead_ch == ch || after_op) bad_expr = 1'b1;
          after_op = 1'b1;
          while (stk_n > 0 && op_stk[stk_n-1] != OP_LPAREN &&
                 rank(op_stk[stk_n-1]) >= rank(code))
            pop_to_output();
          push_code(code);
        end else if (ch == CH_LPAREN) begin
          opens++;
          after_op = 1'b0;
          push_code(OP_LPAREN);
        end else if (ch == CH_RPAREN) begin
          closes++;
          after_op = 1'b0;
          while (stk_n > 0 && op_stk[stk_n-1] != OP_LPAREN) pop_to_output();
          // matched bracket: one extra space; unmatched: nothing more
          if (stk_n > 0) begin
            emit_char(CH_SPACE);
            stk_n--;
          end
        end else begin
          // anything else is an operand; non-digits spoil the verdict
          if (ch < CH_ZERO || ch > CH_NINE) bad_expr = 1'b1;
          after_op = 1'b0;
          emit_char(ch);
          emit_char(CH_SPACE);
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Idling: phases switch every PHASE_LEN accepted items
  // ---------------------------------------------------------------------------
  function automatic int idle_pct(input bit rx);
    case ((n_accepted / PHASE_LEN) % 4)
      1:       return rx ? 0 : 56;
      2:       return rx ? 56 : 0;
      3:       return 18;
      default: return 0;
    endcase
  endfunction

  // Long receiver hold, once, while the sender keeps offering
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_used <= 1'b0;
    end else if (!hold_used && n_accepted >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: model runs on each accepted item
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    infix_item_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tuser  <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        convert_char(s_tuser, s_tdata);
        n_accepted <= n_accepted + 1;
      end
      if (!(s_tvalid && !s_tready)) begin
        if (infix_q.size() > 0 &&
            (hold_left > 0 || $urandom_range(0, 99) >= idle_pct(1'b0))) begin
          nxt = infix_q.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= nxt.is_end;
          s_tdata  <= nxt.ch;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor
  // ---------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      n_errors++;
    end
  endfunction

  always @(posedge clk) begin
    postfix_item_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (postfix_q.size() == 0) begin
          $error("unexpected output item: tdata %h tuser %b tlast %b",
                 m_tdata, m_tuser, m_tlast);
          n_errors++;
        end else begin
          want = postfix_q.pop_front();
          check_field("out_char", want.ch, m_tdata[7:0]);
          check_field("char_valid", want.ch_valid, m_tuser);
          check_field("done_res", want.done, m_tlast);
          check_field("expr_ok", want.ok, m_tdata[8]);
          check_field("stack_overflow", want.ovf, m_tdata[9]);
        end
      end
      m_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= idle_pct(1'b1));
    end
  end

  // Watchdog
  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic push_item(input logic is_end, input logic [7:0] ch);
    infix_q.push_back('{is_end, ch});
  endtask

  task automatic push_text(input string s);
    foreach (s[i]) push_item(1'b0, s[i]);
  endtask

  function automatic logic [7:0] pick_op();
    case ($urandom_range(0, 3))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_STAR;
      default: return CH_SLASH;
    endcase
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 5))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_LF;
      3:       return CH_VT;
      4:       return CH_FF;
      default: return CH_CR;
    endcase
  endfunction

  // Mostly well-formed expressions with random content, some broken; deep
  // ones nest up to 12 brackets and can overflow the operator stack.
  task automatic gen_expr(inout int n_items);
    logic [7:0] txt[$];
    bit         deep;
    bit         want_operand;
    int         depth;
    int         tokens;
    int         cap;
    deep         = ($urandom_range(0, 7) == 0);
    cap          = deep ? 12 : 3;
    tokens       = deep ? $urandom_range(20, 40) : $urandom_range(1, 14);
    want_operand = 1'b1;
    depth        = 0;
    while (tokens > 0 || want_operand) begin
      if ($urandom_range(0, 9) == 0) txt.push_back(pick_blank());
      if (want_operand) begin
        if (depth < cap && $urandom_range(0, 2) < (deep ? 2 : 1) &&
            $urandom_range(0, 1) == (deep ? $urandom_range(0, 1) : 0)) begin
          txt.push_back(CH_LPAREN);
          depth++;
        end else begin
          txt.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
          want_operand = 1'b0;
        end
      end else if (depth > 0 && $urandom_range(0, 2) == 0) begin
        txt.push_back(CH_RPAREN);
        depth--;
      end else begin
        txt.push_back(pick_op());
        want_operand = 1'b1;
      end
      if (tokens > 0) tokens--;
    end
    while (depth > 0) begin
      txt.push_back(CH_RPAREN);
      depth--;
    end
    // occasional damage
    case ($urandom_range(0, 11))
      0: txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom_range(0, 255));
      1: txt.insert($urandom_range(0, txt.size()), pick_op());
      2: if (txt.size() > 1) txt.delete($urandom_range(0, txt.size() - 1));
      3: txt.push_back($urandom_range(0, 1) ? CH_LPAREN : CH_RPAREN);
      4: txt.push_front(pick_op());
      5: txt.push_back(pick_op());
      default: ;
    endcase
    foreach (txt[i]) begin
      push_item(1'b0, txt[i]);
      n_items++;
    end
    push_item(1'b1, 8'($urandom_range(0, 255)));
    n_items++;
  endtask

  initial begin
    int n_random;
    n_random = 0;
    clear_expr();

    // tab first, all operators, two in a row, brackets, illegal high byte, CR
    push_item(1'b0, CH_TAB);
    push_text("3*(4+-5)-6/");
    push_item(1'b0, CH_HIGH);
    push_item(1'b0, CH_CR);
    push_item(1'b1, CH_HIGH);
    // leading operator, unmatched close, NUL, unmatched open, trailing operator
    push_text("-)");
    push_item(1'b0, CH_NUL);
    push_text("(*");
    push_item(1'b1, CH_NUL);
    // blanks only, then a single operand
    push_item(1'b0, CH_LF);
    push_item(1'b0, CH_VT);
    push_item(1'b0, CH_FF);
    push_text(" 7");
    push_item(1'b1, 8'h5A);
    // empty expression
    push_item(1'b1, CH_NUL);

    while (n_random < RANDOM_ITEMS) gen_expr(n_random);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // sample away from the active edge so the driver's updates have landed
    do @(negedge clk);
    while (infix_q.size() > 0 || s_tvalid || postfix_q.size() > 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (postfix_q.size() != 0) begin
      $error("%0d postfix items never arrived", postfix_q.size());
      n_errors++;
    end
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> infix_to_postfix_converter_top.f
rtl/core/i2p_pkg.sv
rtl/core/i2p_front.sv
rtl/core/i2p_queue.sv
rtl/core/i2p_back.sv
rtl/core/infix_to_postfix_converter_top.sv
tb/tb_infix_to_postfix_converter_top.sv
